// ===== design/rfb_pkg.sv =====
// shared types and constants for the response frame builder
`default_nettype none

package rfb_pkg;

	// field widths
	localparam int MAC_W      = 48;
	localparam int IP_W       = 32;
	localparam int PORT_W     = 16;
	localparam int SEQ_W      = 32;
	localparam int LEN_W      = 11;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// stream widths
	localparam int S_TDATA_W = 200;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 2;

	// largest payload accepted
	localparam logic [LEN_W-1:0] MAX_PAYLOAD = 11'd1460;

	// header geometry
	localparam int HDR_TCP_BYTES = 54;
	localparam int HDR_UDP_BYTES = 42;
	localparam int HDR_BITS      = HDR_TCP_BYTES * 8;
	localparam int IDX_W         = 6;

	// protocol numbers and fixed header values
	localparam logic [7:0]  PROTO_TCP   = 8'd6;
	localparam logic [7:0]  PROTO_UDP   = 8'd17;
	localparam logic [15:0] ETH_TYPE_IP = 16'h0800;
	localparam logic [7:0]  IP_VER_IHL  = 8'h45;
	localparam logic [15:0] IP_FLAGS_DF = 16'h4000;
	localparam logic [7:0]  IP_TTL      = 8'd64;
	localparam logic [7:0]  TCP_DOFF    = 8'h50;
	localparam logic [7:0]  TCP_PSH_ACK = 8'h18;
	localparam logic [7:0]  TCP_PSH     = 8'h08;
	localparam logic [15:0] TCP_WINDOW  = 16'hFFFF;
	localparam logic [15:0] TCP_IP_LEN  = 16'd40;
	localparam logic [15:0] UDP_IP_LEN  = 16'd28;
	localparam logic [15:0] UDP_HDR_LEN = 16'd8;

	// checksum sequencer steps
	localparam int SUM_CNT_W = 4;
	localparam logic [SUM_CNT_W-1:0] SUM_FOLD = 4'd9;
	localparam logic [SUM_CNT_W-1:0] SUM_LAST = 4'd10;
	localparam logic [SUM_CNT_W-1:0] SUM_DONE = 4'd11;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REPLY_IP      = 3'd0,
		CFG_REPLY_PORT    = 3'd1,
		CFG_FALLBACK_IP   = 3'd2,
		CFG_FALLBACK_PORT = 3'd3,
		CFG_PROTO         = 3'd4,
		CFG_START_SEQ     = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_ADDR  = 2'd1,
		STAT_PROTO = 2'd2,
		STAT_LEN   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_HDR  = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take_pay;
		logic take_err;
		logic take_start;
		logic hdr_emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic kind;
		logic err;
		logic hdr_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== design/rfb_datapath.sv =====
// datapath: config registers, header fields, checksum sequencer, output register
`default_nettype none

module rfb_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  [rfb_pkg::S_TUSER_W-1:0]    s_tuser,
	input  wire  [rfb_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire                              cfg_we,
	input  wire  [rfb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [rfb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire  rfb_pkg::dp_cmd_t           cmd,
	output rfb_pkg::dp_stat_t                stat,
	output logic                             m_tvalid,
	output logic [rfb_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                             m_tlast,
	output logic [rfb_pkg::M_TUSER_W-1:0]    m_tuser,
	input  wire                              m_tready
);
	import rfb_pkg::*;

	// input fields
	logic              kind;
	logic              has_req;
	logic [MAC_W-1:0]  req_src_mac;
	logic [MAC_W-1:0]  req_dst_mac;
	logic [IP_W-1:0]   req_src_ip;
	logic [PORT_W-1:0] req_src_port;
	logic [SEQ_W-1:0]  req_seq;
	logic [LEN_W-1:0]  payload_len;
	logic [BYTE_W-1:0] payload_byte;

	// config registers
	logic [IP_W-1:0]   reply_ip_q;
	logic [PORT_W-1:0] reply_port_q;
	logic [IP_W-1:0]   fallback_ip_q;
	logic [PORT_W-1:0] fallback_port_q;
	logic [7:0]        proto_q;
	logic [SEQ_W-1:0]  seq_cnt_q;

	// frame state
	logic [LEN_W-1:0]  bytes_left_q;
	logic [IDX_W-1:0]  idx_q;
	logic              tcp_q;
	logic [SUM_CNT_W-1:0] sum_cnt_q;
	logic [19:0]       acc_q;
	logic [15:0]       csum_q;

	// header fields latched at start
	logic [MAC_W-1:0]  dmac_q;
	logic [MAC_W-1:0]  smac_q;
	logic [IP_W-1:0]   dip_q;
	logic [PORT_W-1:0] dport_q;
	logic [15:0]       tot_len_q;
	logic [31:0]       seg_q;
	logic [SEQ_W-1:0]  ack_q;
	logic [7:0]        flags_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	status_t           out_stat_q;

	status_t           err_code;
	logic              is_tcp;
	logic [15:0]       sum_word;
	logic [HDR_BITS-1:0] hdr_vec;
	logic [BYTE_W-1:0] hdr_byte;
	logic              out_free;

	assign kind         = s_tuser[0];
	assign has_req      = s_tuser[1];
	assign req_src_mac  = s_tdata[47:0];
	assign req_dst_mac  = s_tdata[95:48];
	assign req_src_ip   = s_tdata[127:96];
	assign req_src_port = s_tdata[143:128];
	assign req_seq      = s_tdata[175:144];
	assign payload_len  = s_tdata[186:176];
	assign payload_byte = s_tdata[194:187];

	assign is_tcp   = (proto_q == PROTO_TCP);
	assign out_free = !out_valid_q || m_tready;

	// length first, then address and port, then protocol
	always_comb begin
		if (payload_len == '0 || payload_len > MAX_PAYLOAD) begin
			err_code = STAT_LEN;
		end else if (reply_ip_q == '0 || reply_port_q == '0) begin
			err_code = STAT_ADDR;
		end else if (proto_q != PROTO_TCP && proto_q != PROTO_UDP) begin
			err_code = STAT_PROTO;
		end else begin
			err_code = STAT_OK;
		end
	end

	always_comb begin
		stat.out_free = out_free;
		stat.kind     = kind;
		stat.err      = (err_code != STAT_OK);
		stat.hdr_last = (idx_q == (tcp_q ? IDX_W'(HDR_TCP_BYTES - 1)
		                                 : IDX_W'(HDR_UDP_BYTES - 1)));
	end

	// ipv4 header words, one per checksum step
	always_comb begin
		case (sum_cnt_q)
			4'd0:    sum_word = {IP_VER_IHL, 8'h00};
			4'd1:    sum_word = tot_len_q;
			4'd2:    sum_word = 16'h0000;
			4'd3:    sum_word = IP_FLAGS_DF;
			4'd4:    sum_word = {IP_TTL, proto_q};
			4'd5:    sum_word = reply_ip_q[31:16];
			4'd6:    sum_word = reply_ip_q[15:0];
			4'd7:    sum_word = dip_q[31:16];
			4'd8:    sum_word = dip_q[15:0];
			default: sum_word = 16'h0000;
		endcase
	end

	// whole header, first wire byte in the top bits; udp stops after byte 41
	assign hdr_vec = {dmac_q, smac_q, ETH_TYPE_IP,
		IP_VER_IHL, 8'h00, tot_len_q, 16'h0000, IP_FLAGS_DF, IP_TTL, proto_q,
		csum_q, reply_ip_q, dip_q,
		reply_port_q, dport_q, seg_q, ack_q, TCP_DOFF, flags_q, TCP_WINDOW,
		32'h0000_0000};

	assign hdr_byte = hdr_vec[{IDX_W'(HDR_TCP_BYTES - 1) - idx_q, 3'b000} +: BYTE_W];

	// config registers and sequence counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_ip_q      <= '0;
			reply_port_q    <= '0;
			fallback_ip_q   <= '0;
			fallback_port_q <= '0;
			proto_q         <= PROTO_TCP;
			seq_cnt_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REPLY_IP:      reply_ip_q      <= cfg_wdata;
				CFG_REPLY_PORT:    reply_port_q    <= cfg_wdata[PORT_W-1:0];
				CFG_FALLBACK_IP:   fallback_ip_q   <= cfg_wdata;
				CFG_FALLBACK_PORT: fallback_port_q <= cfg_wdata[PORT_W-1:0];
				CFG_PROTO:         proto_q         <= cfg_wdata[7:0];
				CFG_START_SEQ:     seq_cnt_q       <= cfg_wdata;
				default: ;
			endcase
		end else if (cmd.take_start) begin
			seq_cnt_q <= seq_cnt_q + SEQ_W'(payload_len);
		end
	end

	// frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			idx_q        <= '0;
			tcp_q        <= 1'b0;
			sum_cnt_q    <= SUM_DONE;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.take_start) begin
				bytes_left_q <= payload_len;
				idx_q        <= '0;
				tcp_q        <= is_tcp;
				sum_cnt_q    <= '0;
			end else begin
				if (cmd.take_err) begin
					bytes_left_q <= '0;
				end else if (cmd.take_pay && bytes_left_q != '0) begin
					bytes_left_q <= bytes_left_q - 1'b1;
				end
				if (cmd.hdr_emit) begin
					idx_q <= idx_q + 1'b1;
				end
				if (sum_cnt_q != SUM_DONE) begin
					sum_cnt_q <= sum_cnt_q + 1'b1;
				end
			end

			if (cmd.take_err || cmd.hdr_emit ||
			    (cmd.take_pay && bytes_left_q != '0)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// header fields and checksum
	always_ff @(posedge clk) begin
		if (cmd.take_start) begin
			dmac_q    <= has_req ? req_src_mac : '0;
			smac_q    <= has_req ? req_dst_mac : '0;
			dip_q     <= has_req ? req_src_ip : fallback_ip_q;
			dport_q   <= has_req ? req_src_port : fallback_port_q;
			tot_len_q <= 16'(payload_len) + (is_tcp ? TCP_IP_LEN : UDP_IP_LEN);
			seg_q     <= is_tcp ? seq_cnt_q
			                    : {16'(payload_len) + UDP_HDR_LEN, 16'h0000};
			ack_q     <= has_req ? req_seq + 1'b1 : '0;
			flags_q   <= has_req ? TCP_PSH_ACK : TCP_PSH;
			acc_q     <= '0;
		end else if (sum_cnt_q < SUM_FOLD) begin
			acc_q <= acc_q + 20'(sum_word);
		end else if (sum_cnt_q == SUM_FOLD) begin
			acc_q <= 20'(acc_q[15:0]) + 20'(acc_q[19:16]);
		end else if (sum_cnt_q == SUM_LAST) begin
			csum_q <= ~(acc_q[15:0] + 16'(acc_q[16]));
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.take_err) begin
			out_byte_q <= '0;
			out_last_q <= 1'b1;
			out_stat_q <= err_code;
		end else if (cmd.hdr_emit) begin
			out_byte_q <= hdr_byte;
			out_last_q <= 1'b0;
			out_stat_q <= STAT_OK;
		end else if (cmd.take_pay && bytes_left_q != '0) begin
			out_byte_q <= payload_byte;
			out_last_q <= (bytes_left_q == LEN_W'(1));
			out_stat_q <= STAT_OK;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_stat_q;

endmodule

`default_nettype wire

// ===== design/rfb_ctrl.sv =====
// controller: input acceptance and header emission sequencing
`default_nettype none

module rfb_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	input  wire rfb_pkg::dp_stat_t stat,
	output rfb_pkg::dp_cmd_t   cmd
);
	import rfb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				s_tready = stat.out_free;
				if (s_tvalid && stat.out_free) begin
					if (stat.kind) begin
						cmd.take_pay = 1'b1;
					end else if (stat.err) begin
						cmd.take_err = 1'b1;
					end else begin
						cmd.take_start = 1'b1;
						state_d        = S_HDR;
					end
				end
			end
			S_HDR: begin
				if (stat.out_free) begin
					cmd.hdr_emit = 1'b1;
					if (stat.hdr_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/response_frame_builder.sv =====
// top level of the response frame builder
//
// takes items on the s_ stream and produces reply frame bytes on the m_ stream.
// a start item (s_tuser kind 0) is checked first; a bad length, a zero reply
// address or port, or an unsupported protocol gives a single error item with
// m_tlast set and the status code on m_tuser. otherwise the block emits the
// ethernet, ipv4 and tcp or udp header, one byte per cycle unless the receiver
// stalls: 54 bytes for tcp, 42 for udp, once the controller has entered its
// header state. no input item is taken while the header goes out. payload
// items (kind 1) pass through the output register at one item per cycle unless
// the receiver stalls; m_tlast marks the last payload byte. payload items that
// arrive with no frame open are dropped.
// the ipv4 checksum is worked out by a sequencer that adds one header word per
// cycle and folds the carries, finishing before the checksum bytes are due.
// a single output register holds each result; while the receiver stalls it
// holds its item and the block takes no new input item.
// reset clears the config registers (protocol back to tcp), the sequence
// counter and any open frame. config writes belong to idle periods.
`default_nettype none

module response_frame_builder (
	input  wire                              clk,
	input  wire                              arst_n,
	// slave stream
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// req_src_mac, req_dst_mac, req_src_ip, req_src_port, req_seq,
	// payload_len, payload_byte, zero pad
	input  wire  [rfb_pkg::S_TDATA_W-1:0]    s_tdata,
	// kind, has_request
	input  wire  [rfb_pkg::S_TUSER_W-1:0]    s_tuser,
	// master stream
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// frame_byte
	output logic [rfb_pkg::M_TDATA_W-1:0]    m_tdata,
	// end_of_frame
	output logic                             m_tlast,
	// status
	output logic [rfb_pkg::M_TUSER_W-1:0]    m_tuser,
	// config write port
	input  wire                              cfg_we,
	input  wire  [rfb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [rfb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import rfb_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// state machine: idle/accept vs. header emission
	rfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// registers, header assembly, checksum, output stage
	rfb_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.m_tready  (m_tready)
	);

endmodule

`default_nettype wire

// ===== design/rfb_checker.sv =====
// port-level checks for the response frame builder, bound to the top level
`default_nettype none

module rfb_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_tvalid,
	input wire                            s_tready,
	input wire [rfb_pkg::S_TUSER_W-1:0]   s_tuser,
	input wire                            m_tvalid,
	input wire                            m_tready,
	input wire [rfb_pkg::M_TDATA_W-1:0]   m_tdata,
	input wire                            m_tlast,
	input wire [rfb_pkg::M_TUSER_W-1:0]   m_tuser
);
	import rfb_pkg::*;

	// a stalled item stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	// a stalled item keeps its content
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("output item changed while stalled");

	// an error item ends the frame and carries no byte
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tlast && m_tdata == '0)
		else $error("error item without end of frame or with data");

	// input is only taken when the output side can move
	a_no_input_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("input taken while output stalled");

	// a start item either gives an error item or blocks input for its header
	a_start_follow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] |=> !s_tready || m_tvalid)
		else $error("start item produced nothing");

endmodule

bind response_frame_builder rfb_checker u_rfb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire
